### sv/jet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_pkg: shared types, constants and helpers for the Julia escape-time block
// Fixed-point format, register indexes, sequencer states and saturation
// helpers used by the iterator datapath.
// ----------------------------------------------------------------------------
package jet_pkg;

    // Q4.28 signed fixed point, 32 bits wide
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * DATA_W;

    // iteration counter and limit register
    localparam int ITER_BITS = 12;
    localparam int OUT_TDATA_W = ((ITER_BITS + 7) / 8) * 8;

    // |z|^2 >= 4 in the product format (2*FRAC_BITS fraction bits)
    localparam int ESC_SHIFT = 2 + 2 * FRAC_BITS;

    // configuration port
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_SCALE  = 3'd0,
        REG_Y_SCALE  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_OFFSET_Y = 3'd3,
        REG_C_REAL   = 3'd4,
        REG_C_IMAG   = 3'd5,
        REG_MAX_ITER = 3'd6
    } cfg_reg_t;

    // reset values of the registers
    localparam logic signed [DATA_W-1:0] X_SCALE_RST  = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] Y_SCALE_RST  = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] OFFSET_X_RST = 32'sd536870912;
    localparam logic signed [DATA_W-1:0] OFFSET_Y_RST = 32'sd536870912;
    localparam logic [ITER_BITS-1:0]     MAX_ITER_RST = 12'd100;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_FIN_Y,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } state_t;

    localparam logic signed [PROD_W-1:0] SAT_MAX64 =
        {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN64 =
        {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // clamp a 64-bit signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX64) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < SAT_MIN64) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // clamp a 33-bit signed difference to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        priority if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/julia_escape_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// julia_escape_time: Julia-set escape-time iterator
// Maps a pixel to a Q4.28 start point, iterates z = z^2 + c on one shared
// 32x32 signed multiplier and returns the number of iterations done.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | s_tvalid/s_tready  | s_tdata: pixel_x, pixel_y (low bits up)
//  result   | m_tvalid/m_tready  | m_tdata: iteration_count
//  config   | cfg_wr_en          | cfg_addr, cfg_wdata (no read-back)
//
//  The shared multiplier is used for the two mapping products and then three
//  times per iteration (zr^2, zi^2, zr*zi), one product per cycle.
//  s_tready is high only while the sequencer is idle. The result sits in an
//  output register, so a stalled result blocks only the finish of the next
//  item. aresetn is synchronous, active low, and restores register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time #(
    parameter int PIXEL_BITS = 11
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input items
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    // [PIXEL_BITS-1:0] pixel_x, [2*PIXEL_BITS-1:PIXEL_BITS] pixel_y, zero fill
    input  wire logic [((2*PIXEL_BITS+7)/8)*8-1:0]      s_tdata,
    // result items
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // [ITER_BITS-1:0] iteration_count, zero fill
    output      logic [jet_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire logic                                   cfg_wr_en,
    input  wire logic [jet_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [jet_pkg::DATA_W-1:0]             cfg_wdata
);

    localparam int DW = jet_pkg::DATA_W;
    localparam int PW = jet_pkg::PROD_W;
    localparam int IB = jet_pkg::ITER_BITS;

    // configuration registers
    logic signed [DW-1:0] x_scale_reg, y_scale_reg, offset_x_reg, offset_y_reg;
    logic signed [DW-1:0] c_real_reg, c_imag_reg;
    logic [IB-1:0]        max_iter_reg;

    // sequencer and datapath
    jet_pkg::state_t      state_reg, state_next;
    logic [PIXEL_BITS-1:0] px_reg, py_reg;
    logic signed [DW-1:0] zr_reg, zi_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] sq_r_reg;
    logic signed [PW-1:0] diff_reg;
    logic [IB-1:0]        count_reg;

    // output register
    logic                 out_valid_reg;
    logic [IB-1:0]        out_count_reg;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [DW-1:0] map_sat;
    logic [PW-1:0]        mag;
    logic                 escaped;
    logic                 limit_hit;
    logic                 out_free;
    logic                 load_out;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_scale_reg  <= jet_pkg::X_SCALE_RST;
            y_scale_reg  <= jet_pkg::Y_SCALE_RST;
            offset_x_reg <= jet_pkg::OFFSET_X_RST;
            offset_y_reg <= jet_pkg::OFFSET_Y_RST;
            c_real_reg   <= '0;
            c_imag_reg   <= '0;
            max_iter_reg <= jet_pkg::MAX_ITER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                jet_pkg::REG_X_SCALE:  x_scale_reg  <= cfg_wdata;
                jet_pkg::REG_Y_SCALE:  y_scale_reg  <= cfg_wdata;
                jet_pkg::REG_OFFSET_X: offset_x_reg <= cfg_wdata;
                jet_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                jet_pkg::REG_C_REAL:   c_real_reg   <= cfg_wdata;
                jet_pkg::REG_C_IMAG:   c_imag_reg   <= cfg_wdata;
                jet_pkg::REG_MAX_ITER: max_iter_reg <= cfg_wdata[IB-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            jet_pkg::ST_MAP_X: begin
                mul_a = $signed({{(DW-PIXEL_BITS){1'b0}}, px_reg});
                mul_b = x_scale_reg;
            end
            jet_pkg::ST_MAP_Y: begin
                mul_a = $signed({{(DW-PIXEL_BITS){1'b0}}, py_reg});
                mul_b = y_scale_reg;
            end
            jet_pkg::ST_SQ_R: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            jet_pkg::ST_SQ_I: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // scaled coordinate clamped to 32 bits before the offset
    assign map_sat = jet_pkg::sat64(prod_reg);

    // |z|^2 = zr^2 + zi^2, both squares non-negative; zi^2 is in prod_reg
    assign mag       = $unsigned(sq_r_reg) + $unsigned(prod_reg);
    assign escaped   = (mag >> jet_pkg::ESC_SHIFT) != '0;
    assign limit_hit = (count_reg == max_iter_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            jet_pkg::ST_IDLE:   if (s_tvalid) state_next = jet_pkg::ST_MAP_X;
            jet_pkg::ST_MAP_X:  state_next = jet_pkg::ST_MAP_Y;
            jet_pkg::ST_MAP_Y:  state_next = jet_pkg::ST_FIN_Y;
            jet_pkg::ST_FIN_Y:  state_next = jet_pkg::ST_SQ_R;
            jet_pkg::ST_SQ_R:   state_next = limit_hit ? jet_pkg::ST_DONE : jet_pkg::ST_SQ_I;
            jet_pkg::ST_SQ_I:   state_next = jet_pkg::ST_CROSS;
            jet_pkg::ST_CROSS:  state_next = escaped ? jet_pkg::ST_DONE : jet_pkg::ST_UPDATE;
            jet_pkg::ST_UPDATE: state_next = jet_pkg::ST_SQ_R;
            jet_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = jet_pkg::ST_IDLE;
                end
            end
            default:            state_next = jet_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jet_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        unique case (state_reg)
            jet_pkg::ST_IDLE: begin
                px_reg    <= s_tdata[PIXEL_BITS-1:0];
                py_reg    <= s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
                count_reg <= '0;
            end
            jet_pkg::ST_MAP_Y: begin
                zr_reg <= jet_pkg::sat33($signed({map_sat[DW-1], map_sat})
                                         - $signed({offset_x_reg[DW-1], offset_x_reg}));
            end
            jet_pkg::ST_FIN_Y: begin
                zi_reg <= jet_pkg::sat33($signed({map_sat[DW-1], map_sat})
                                         - $signed({offset_y_reg[DW-1], offset_y_reg}));
            end
            jet_pkg::ST_SQ_I: begin
                sq_r_reg <= prod_reg;
            end
            jet_pkg::ST_CROSS: begin
                // zr^2 - zi^2 in the product format
                diff_reg <= sq_r_reg - prod_reg;
            end
            jet_pkg::ST_UPDATE: begin
                // arithmetic shifts round toward minus infinity
                zr_reg    <= jet_pkg::sat64((diff_reg >>> jet_pkg::FRAC_BITS)
                                            + PW'(c_real_reg));
                zi_reg    <= jet_pkg::sat64((prod_reg >>> (jet_pkg::FRAC_BITS - 1))
                                            + PW'(c_imag_reg));
                count_reg <= count_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_count_reg <= count_reg;
        end
    end

    assign s_tready = (state_reg == jet_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(jet_pkg::OUT_TDATA_W-IB){1'b0}}, out_count_reg};

endmodule
`default_nettype wire

### tb/sv/jet_checker.sv
// ----------------------------------------------------------------------------
// jet_checker: escape-time predictor and result scoreboard
// Mirrors the register writes, computes the iteration count of every pixel
// taken on the input channel and compares each result item, in order, with
// the oldest count still waiting.
// ----------------------------------------------------------------------------
module jet_checker #(
    parameter int PIXEL_BITS = 11
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    // [PIXEL_BITS-1:0] pixel_x, [2*PIXEL_BITS-1:PIXEL_BITS] pixel_y, zero fill
    input  wire logic [((2*PIXEL_BITS+7)/8)*8-1:0]   s_tdata,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [ITER_BITS-1:0] iteration_count, zero fill
    input  wire logic [jet_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [jet_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [jet_pkg::DATA_W-1:0]          cfg_wdata,
    output int                                       fail_count,
    output int                                       pixels_taken,
    output int                                       counts_retired
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITER_W = jet_pkg::ITER_BITS;
    localparam int FRAC   = jet_pkg::FRAC_BITS;
    // |z|^2 >= 4 with 2*FRAC fraction bits in the squares
    localparam int ESCAPE_POW = 2 + 2 * FRAC;

    localparam logic signed [31:0] X_STEP_DEFAULT  = 32'sd1048576;
    localparam logic signed [31:0] Y_STEP_DEFAULT  = 32'sd1048576;
    localparam logic signed [31:0] X_SHIFT_DEFAULT = 32'sd536870912;
    localparam logic signed [31:0] Y_SHIFT_DEFAULT = 32'sd536870912;
    localparam logic [ITER_W-1:0]  LIMIT_DEFAULT   = 12'd100;

    typedef struct {
        logic [PIXEL_BITS-1:0] px;
        logic [PIXEL_BITS-1:0] py;
        logic [ITER_W-1:0]     count;
    } orbit_t;

    // register mirror
    logic signed [31:0] x_step, y_step, x_shift, y_shift, c_re, c_im;
    logic [ITER_W-1:0]  iter_limit;

    orbit_t expected_counts[$];

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > longint'(32'sh7fff_ffff))
            return 32'sh7fff_ffff;
        if (v < -longint'(32'sh7fff_ffff) - 1)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic escaped(input logic signed [31:0] zr,
                                     input logic signed [31:0] zi);
        logic [64:0] mag;
        mag = {1'b0, 64'(longint'(zr) * longint'(zr))} +
              {1'b0, 64'(longint'(zi) * longint'(zi))};
        if (ESCAPE_POW >= 64)
            return 1'b0;
        return mag >= (65'd1 << ESCAPE_POW);
    endfunction

    // iterations of z = z^2 + c before escape or the limit
    function automatic logic [ITER_W-1:0] orbit_length(input logic [PIXEL_BITS-1:0] px,
                                                       input logic [PIXEL_BITS-1:0] py);
        logic signed [31:0] zr, zi;
        longint re_sq, im_sq, cross_term;
        logic [ITER_W-1:0] n;
        zr = clamp_q(longint'(clamp_q(longint'(px) * longint'(x_step))) - longint'(x_shift));
        zi = clamp_q(longint'(clamp_q(longint'(py) * longint'(y_step))) - longint'(y_shift));
        n = '0;
        while (n < iter_limit && !escaped(zr, zi)) begin
            re_sq      = longint'(zr) * longint'(zr);
            im_sq      = longint'(zi) * longint'(zi);
            cross_term = longint'(zr) * longint'(zi);
            // arithmetic shifts round toward minus infinity
            zr = clamp_q(((re_sq - im_sq) >>> FRAC) + longint'(c_re));
            zi = clamp_q((cross_term >>> (FRAC - 1)) + longint'(c_im));
            n = n + 1'b1;
        end
        return n;
    endfunction

    always @(posedge aclk) begin
        orbit_t item;
        orbit_t want;
        if (!aresetn) begin
            x_step     = X_STEP_DEFAULT;
            y_step     = Y_STEP_DEFAULT;
            x_shift    = X_SHIFT_DEFAULT;
            y_shift    = Y_SHIFT_DEFAULT;
            c_re       = '0;
            c_im       = '0;
            iter_limit = LIMIT_DEFAULT;
            expected_counts.delete();
            fail_count     <= 0;
            pixels_taken   <= 0;
            counts_retired <= 0;
        end else begin
            // register writes; unknown indexes fall through
            if (cfg_wr_en) begin
                case (cfg_addr)
                    jet_pkg::REG_X_SCALE:  x_step     = cfg_wdata;
                    jet_pkg::REG_Y_SCALE:  y_step     = cfg_wdata;
                    jet_pkg::REG_OFFSET_X: x_shift    = cfg_wdata;
                    jet_pkg::REG_OFFSET_Y: y_shift    = cfg_wdata;
                    jet_pkg::REG_C_REAL:   c_re       = cfg_wdata;
                    jet_pkg::REG_C_IMAG:   c_im       = cfg_wdata;
                    jet_pkg::REG_MAX_ITER: iter_limit = cfg_wdata[ITER_W-1:0];
                    default: ;
                endcase
            end

            // predict on every accepted pixel
            if (s_tvalid && s_tready) begin
                item.px    = s_tdata[PIXEL_BITS-1:0];
                item.py    = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
                item.count = orbit_length(item.px, item.py);
                expected_counts.push_back(item);
                pixels_taken <= pixels_taken + 1;
            end

            // compare every accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: result item %0d arrived with no pixel outstanding",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_counts.pop_front();
                    counts_retired <= counts_retired + 1;
                    if (m_tdata !== jet_pkg::OUT_TDATA_W'(want.count)) begin
                        $display("%0t: pixel (%0d,%0d) iteration_count expected %0d got %0d",
                                 $time, want.px, want.py, want.count, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for julia_escape_time
// Drives pixels through directed corner views (saturating mappings, zero and
// full iteration limits, ignored register index) and then random views, with
// random gaps and stalls on both channels; jet_checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_BITS   = 11;
    localparam int IN_W         = ((2 * PIXEL_BITS + 7) / 8) * 8;
    localparam int PIX_MAX      = (1 << PIXEL_BITS) - 1;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int ROUNDS       = 6;
    localparam int ROUND_PIXELS = 64;

    localparam logic [jet_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sd268435456;

    typedef struct {
        logic signed [31:0] x_step, y_step, x_shift, y_shift, c_re, c_im;
        logic [11:0]        limit;
    } view_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid, s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [jet_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en;
    logic [jet_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [jet_pkg::DATA_W-1:0] cfg_wdata;

    int fail_count, pixels_taken, counts_retired;
    int views_loaded;
    bit steady;
    int hold_req;

    julia_escape_time #(.PIXEL_BITS(PIXEL_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    jet_checker #(.PIXEL_BITS(PIXEL_BITS)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pixels_taken(pixels_taken),
        .counts_retired(counts_retired)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // one register write; the caller drops cfg_wr_en after its last write
    task automatic write_reg(input logic [jet_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_view(input view_t v);
        write_reg(jet_pkg::REG_X_SCALE,  v.x_step);
        write_reg(jet_pkg::REG_Y_SCALE,  v.y_step);
        write_reg(jet_pkg::REG_OFFSET_X, v.x_shift);
        write_reg(jet_pkg::REG_OFFSET_Y, v.y_shift);
        write_reg(jet_pkg::REG_C_REAL,   v.c_re);
        write_reg(jet_pkg::REG_C_IMAG,   v.c_im);
        write_reg(jet_pkg::REG_MAX_ITER, 32'(v.limit));
        cfg_wr_en <= 1'b0;
        views_loaded++;
    endtask

    // offer one pixel, with a random gap first unless the phase runs steady
    task automatic send_pixel(input int px, input int py);
        logic [IN_W-1:0] word;
        int pick, gap;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[PIXEL_BITS-1:0] = px[PIXEL_BITS-1:0];
        word[2*PIXEL_BITS-1:PIXEL_BITS] = py[PIXEL_BITS-1:0];
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering, wait for every outstanding count, then let the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pixels_taken != counts_retired) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result side: random ready, with a long hold-off on request
    initial begin
        int hold_served;
        int pick;
        hold_served = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_req != hold_served) begin
                hold_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (steady || pick < 60) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else if (pick < 90) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d of %0d counts back", counts_retired, pixels_taken);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        view_t v;
        int mode, sx, sy, cx, cy;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        steady    = 1'b0;
        hold_req  = 0;
        views_loaded = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset view: corners outside, center stays at 0 up to the limit;
        // the receiver holds off so the output stalls and input backs up
        hold_req++;
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MAX, 0);
        send_pixel(0, PIX_MAX);
        send_pixel(512, 512);
        send_pixel(600, 530);
        drain();

        // zero limit, written with junk in the unused high bits
        write_reg(jet_pkg::REG_MAX_ITER, 32'hffff_f000);
        cfg_wr_en <= 1'b0;
        send_pixel(512, 512);
        send_pixel(1000, 700);
        drain();

        // limit of 60 through masked bits, then a write to an unused index
        write_reg(jet_pkg::REG_MAX_ITER, {20'habcde, 12'd60});
        write_reg(REG_UNUSED, 32'h8000_0001);
        cfg_wr_en <= 1'b0;
        send_pixel(512, 512);
        send_pixel(700, 400);
        send_pixel(300, 900);
        drain();

        // saturating mapping at the register extremes
        v = '{x_step: Q_MAX, y_step: Q_MIN, x_shift: Q_MIN, y_shift: Q_MAX,
              c_re: Q_MAX, c_im: Q_MIN, limit: 12'd1};
        load_view(v);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(1024, 3);
        drain();

        // start at 1.9i, extreme c drives both saturations inside the loop
        v = '{x_step: '0, y_step: '0, x_shift: '0, y_shift: -32'sd510027366,
              c_re: Q_MIN, c_im: Q_MAX, limit: 12'hfff};
        load_view(v);
        send_pixel(5, 9);
        send_pixel(PIX_MAX, 0);
        drain();

        // full limit: two bounded orbits and one escaping pixel
        v = '{x_step: 32'sd1048576, y_step: 32'sd1048576, x_shift: 32'sd536870912,
              y_shift: 32'sd536870912, c_re: '0, c_im: '0, limit: 12'hfff};
        load_view(v);
        send_pixel(512, 512);
        send_pixel(700, 700);
        send_pixel(400, 400);
        drain();

        // random views
        for (int r = 0; r < ROUNDS; r++) begin
            mode = $urandom_range(0, 3);
            if (mode == 2) begin
                v.x_step  = $urandom;
                v.y_step  = $urandom;
                v.x_shift = $urandom;
                v.y_shift = $urandom;
                v.c_re    = $urandom;
                v.c_im    = $urandom;
            end else begin
                // a window over the interesting region, mirrored or zoomed
                sx = (mode == 3) ? $urandom_range(1 << 12, 1 << 16)
                                 : $urandom_range(1 << 17, 1 << 20);
                sy = (mode == 3) ? $urandom_range(1 << 12, 1 << 16)
                                 : $urandom_range(1 << 17, 1 << 20);
                if (mode == 1) begin
                    sx = -sx;
                    sy = -sy;
                end
                cx = $urandom_range(256, 1792);
                cy = $urandom_range(256, 1792);
                v.x_step  = sx;
                v.y_step  = sy;
                v.x_shift = sx * cx;
                v.y_shift = sy * cy;
                v.c_re    = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
                v.c_im    = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
            end
            v.limit = 12'($urandom_range(1, 255));
            load_view(v);
            steady = (r == 2);
            if (r == 4)
                hold_req++;
            for (int k = 0; k < ROUND_PIXELS; k++)
                send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
            drain();
            steady = 1'b0;
        end

        $display("covered %0d pixels over %0d register views, %0d counts compared",
                 pixels_taken, views_loaded, counts_retired);
        $display("views included saturating maps, zero and full limits, ignored index");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
sv/jet_pkg.sv
sv/julia_escape_time.sv
tb/sv/jet_checker.sv
tb/sv/tb.sv
